[rtl/bfa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

	localparam int MAX_FRAMES    = 65536;
	localparam int BITS_PER_WORD = 32;
	localparam int WORDS         = MAX_FRAMES / BITS_PER_WORD;
	localparam int WORD_AW       = $clog2(WORDS);
	localparam int BIT_W         = $clog2(BITS_PER_WORD);
	localparam int PAGE_SHIFT    = 12;
	localparam int IDX_W         = 16;
	localparam int CNT_W         = 17;
	localparam int ADDR_W        = 48;
	localparam int IN_W          = 88;
	localparam int OUT_W         = 88;
	localparam int PADDR_W       = 6;
	localparam int PDATA_W       = 64;

	// commands
	localparam logic [2:0] CMD_ALLOC    = 3'd0;
	localparam logic [2:0] CMD_FREE     = 3'd1;
	localparam logic [2:0] CMD_IS_FREE  = 3'd2;
	localparam logic [2:0] CMD_ADDR_OF  = 3'd3;
	localparam logic [2:0] CMD_INDEX_OF = 3'd4;
	localparam logic [2:0] CMD_ALLOC_RUN = 3'd5;
	localparam logic [2:0] CMD_USED     = 3'd6;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_ALREADY = 2'd1;
	localparam logic [1:0] ST_FAIL    = 2'd2;

	// register indexes
	localparam logic [2:0] REG_R0_BASE   = 3'd0;
	localparam logic [2:0] REG_R0_FRAMES = 3'd1;
	localparam logic [2:0] REG_R1_BASE   = 3'd2;
	localparam logic [2:0] REG_R1_FRAMES = 3'd3;
	localparam logic [2:0] REG_TOTAL     = 3'd4;

	typedef struct packed {
		logic [ADDR_W-1:0] r0_base;
		logic [CNT_W-1:0]  r0_frames;
		logic [ADDR_W-1:0] r1_base;
		logic [CNT_W-1:0]  r1_frames;
		logic [CNT_W-1:0]  total;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic clr;
		logic exec;
		logic scan_init;
		logic scan_rd;
		logic scan_bit;
		logic scan_fail;
		logic fill_rd;
		logic fill_wr;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic       clr_done;
		logic [2:0] cmd;
		logic       run_zero;
		logic       scan_end;
		logic       scan_found;
		logic       scan_next_rd;
		logic       fill_last;
		logic       out_busy;
	} ctl_sts_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EXEC,
		S_SCAN_RD,
		S_SCAN_BIT,
		S_FILL_RD,
		S_FILL_WR,
		S_DONE
	} state_t;

endpackage

[rtl/bfa_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module bfa_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bfa_pkg::PADDR_W-1:0]  paddr,
	input  logic [bfa_pkg::PDATA_W-1:0]  pwdata,
	output logic [bfa_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output bfa_pkg::cfg_t                cfg
);

	bfa_pkg::cfg_t cfg_q;
	logic [2:0]    reg_sel;
	logic          wr_en;

	assign reg_sel = paddr[bfa_pkg::PADDR_W-1:3];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				bfa_pkg::REG_R0_BASE:   cfg_q.r0_base   <= pwdata[bfa_pkg::ADDR_W-1:0];
				bfa_pkg::REG_R0_FRAMES: cfg_q.r0_frames <= pwdata[bfa_pkg::CNT_W-1:0];
				bfa_pkg::REG_R1_BASE:   cfg_q.r1_base   <= pwdata[bfa_pkg::ADDR_W-1:0];
				bfa_pkg::REG_R1_FRAMES: cfg_q.r1_frames <= pwdata[bfa_pkg::CNT_W-1:0];
				bfa_pkg::REG_TOTAL:     cfg_q.total     <= pwdata[bfa_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			bfa_pkg::REG_R0_BASE:   prdata = 64'(cfg_q.r0_base);
			bfa_pkg::REG_R0_FRAMES: prdata = 64'(cfg_q.r0_frames);
			bfa_pkg::REG_R1_BASE:   prdata = 64'(cfg_q.r1_base);
			bfa_pkg::REG_R1_FRAMES: prdata = 64'(cfg_q.r1_frames);
			bfa_pkg::REG_TOTAL:     prdata = 64'(cfg_q.total);
			default:                prdata = '0;
		endcase
	end

endmodule

[rtl/bfa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer: bitmap clearing, single-frame read-modify-write, run search
// and run fill, result hand-off.
// ----------------------------------------------------------------------------
module bfa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  bfa_pkg::ctl_sts_t  sts,
	output bfa_pkg::ctl_cmd_t  cmd
);

	bfa_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfa_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			bfa_pkg::S_CLEAR: begin
				if (sts.clr_done) begin
					state_d = bfa_pkg::S_IDLE;
				end else begin
					cmd.clr = 1'b1;
				end
			end
			bfa_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = bfa_pkg::S_READ;
				end
			end
			bfa_pkg::S_READ: begin
				if (sts.cmd == bfa_pkg::CMD_ALLOC_RUN && !sts.run_zero) begin
					cmd.scan_init = 1'b1;
					state_d       = bfa_pkg::S_SCAN_RD;
				end else begin
					state_d = bfa_pkg::S_EXEC;
				end
			end
			bfa_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = bfa_pkg::S_DONE;
			end
			bfa_pkg::S_SCAN_RD: begin
				if (sts.scan_end) begin
					cmd.scan_fail = 1'b1;
					state_d       = bfa_pkg::S_DONE;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d     = bfa_pkg::S_SCAN_BIT;
				end
			end
			bfa_pkg::S_SCAN_BIT: begin
				cmd.scan_bit = 1'b1;
				priority if (sts.scan_found) begin
					state_d = bfa_pkg::S_FILL_RD;
				end else if (sts.scan_next_rd) begin
					state_d = bfa_pkg::S_SCAN_RD;
				end
			end
			bfa_pkg::S_FILL_RD: begin
				cmd.fill_rd = 1'b1;
				state_d     = bfa_pkg::S_FILL_WR;
			end
			bfa_pkg::S_FILL_WR: begin
				cmd.fill_wr = 1'b1;
				state_d     = sts.fill_last ? bfa_pkg::S_DONE : bfa_pkg::S_FILL_RD;
			end
			bfa_pkg::S_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = bfa_pkg::S_IDLE;
				end
			end
			default: state_d = bfa_pkg::S_IDLE;
		endcase
	end

endmodule

[rtl/bfa_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_dp
// Datapath: frame bitmap memory, used counter, translation arithmetic,
// run search counters and the output register.
// ----------------------------------------------------------------------------
module bfa_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bfa_pkg::cfg_t              cfg,
	input  bfa_pkg::ctl_cmd_t          cmd,
	output bfa_pkg::ctl_sts_t          sts,
	input  logic [bfa_pkg::IN_W-1:0]   s_tdata,
	input  logic [2:0]                 s_tuser,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [bfa_pkg::OUT_W-1:0]  m_tdata
);

	localparam int AW = bfa_pkg::ADDR_W;
	localparam int CW = bfa_pkg::CNT_W;
	localparam int IW = bfa_pkg::IDX_W;
	localparam int WA = bfa_pkg::WORD_AW;
	localparam int BW = bfa_pkg::BIT_W;
	localparam int PS = bfa_pkg::PAGE_SHIFT;
	localparam int DW = bfa_pkg::BITS_PER_WORD;

	// item registers
	logic [2:0]    cmd_q;
	logic [IW-1:0] fidx_q;
	logic [AW-1:0] addr_q;
	logic [CW-1:0] runlen_q;

	// bitmap memory
	logic [DW-1:0] mem [bfa_pkg::WORDS];
	logic [DW-1:0] rdata_q;
	logic [WA-1:0] mem_a;
	logic [DW-1:0] mem_wd;
	logic          mem_we;
	logic [WA:0]   clr_cnt_q;

	// counters and results
	logic [CW-1:0] used_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] combo_q;
	logic [IW-1:0] start_q;
	logic [IW-1:0] end_q;
	logic [WA-1:0] fw_q;
	logic [IW-1:0] res_index_q;
	logic [AW-1:0] res_addr_q;
	logic          res_free_q;
	logic [1:0]    res_status_q;
	logic          m_tvalid_q;
	logic [bfa_pkg::OUT_W-1:0] m_tdata_q;

	// single-frame terms
	logic [CW:0]   r_tot;
	logic          item_ok;
	logic          in_r0;
	logic [IW-1:0] local_idx;
	logic [AW-1:0] base_sel;
	logic [AW-1:0] pa;
	logic          cur_bit;
	logic [DW-1:0] onehot;
	logic          item_we;

	// index-of terms
	logic [AW:0]   e0, e1;
	logic          hit0, hit1;
	logic [AW-1:0] d0, d1;
	logic [36:0]   g0, g1;

	// scan / fill terms
	logic          free_b;
	logic [CW-1:0] combo_p1;
	logic          found;
	logic [IW-1:0] st;
	logic [CW-1:0] end_full;
	logic [DW-1:0] fill_mask;
	logic [IW-1:0] pos;

	assign r_tot     = {1'b0, cfg.r0_frames} + {1'b0, cfg.r1_frames};
	assign item_ok   = {2'b0, fidx_q} < r_tot;
	assign in_r0     = {1'b0, fidx_q} < cfg.r0_frames;
	assign local_idx = in_r0 ? fidx_q : fidx_q - cfg.r0_frames[IW-1:0];
	assign base_sel  = in_r0 ? cfg.r0_base : cfg.r1_base;
	assign pa        = base_sel + {local_idx, PS'(0)};
	assign cur_bit   = rdata_q[fidx_q[BW-1:0]];
	assign onehot    = DW'(1) << fidx_q[BW-1:0];
	assign item_we   = cmd.exec && item_ok &&
		((cmd_q == bfa_pkg::CMD_ALLOC && !cur_bit) || (cmd_q == bfa_pkg::CMD_FREE && cur_bit));

	assign e0   = {1'b0, cfg.r0_base} + {20'b0, cfg.r0_frames, PS'(0)};
	assign e1   = {1'b0, cfg.r1_base} + {20'b0, cfg.r1_frames, PS'(0)};
	assign hit0 = (addr_q >= cfg.r0_base) && ({1'b0, addr_q} < e0);
	assign hit1 = (addr_q >= cfg.r1_base) && ({1'b0, addr_q} < e1);
	assign d0   = addr_q - cfg.r0_base;
	assign d1   = addr_q - cfg.r1_base;
	assign g0   = {1'b0, d0[AW-1:PS]};
	assign g1   = {1'b0, d1[AW-1:PS]} + {20'b0, cfg.r0_frames};

	assign free_b   = ({2'b0, i_q} < {1'b0, r_tot}) && !rdata_q[i_q[BW-1:0]];
	assign combo_p1 = combo_q + CW'(1);
	assign found    = free_b && (combo_p1 == runlen_q);
	assign st       = (combo_q == '0) ? i_q[IW-1:0] : start_q;
	assign end_full = {1'b0, st} + runlen_q - CW'(1);

	always_comb begin
		for (int b = 0; b < DW; b++) begin
			pos          = {fw_q, BW'(b)};
			fill_mask[b] = (pos >= start_q) && (pos <= end_q);
		end
	end

	// memory port selection
	always_comb begin
		mem_a  = fidx_q[IW-1:BW];
		mem_wd = (cmd_q == bfa_pkg::CMD_ALLOC) ? (rdata_q | onehot) : (rdata_q & ~onehot);
		mem_we = item_we;
		priority if (cmd.clr) begin
			mem_a  = clr_cnt_q[WA-1:0];
			mem_wd = '0;
			mem_we = 1'b1;
		end else if (cmd.scan_rd || cmd.scan_bit) begin
			// hold the scanned word in the read register while its bits are walked
			mem_a  = i_q[IW-1:BW];
			mem_we = 1'b0;
		end else if (cmd.fill_rd || cmd.fill_wr) begin
			mem_a  = fw_q;
			mem_wd = rdata_q | fill_mask;
			mem_we = cmd.fill_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_a] <= mem_wd;
		end
		rdata_q <= mem[mem_a];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// item capture and result staging
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q    <= s_tuser;
			fidx_q   <= s_tdata[15:0];
			addr_q   <= s_tdata[63:16];
			runlen_q <= s_tdata[80:64];
		end
		if (cmd.exec) begin
			res_index_q  <= '0;
			res_addr_q   <= '0;
			res_free_q   <= 1'b0;
			res_status_q <= bfa_pkg::ST_OK;
			if (cmd_q <= bfa_pkg::CMD_ADDR_OF) begin
				res_index_q <= fidx_q;
				if (!item_ok) begin
					res_status_q <= bfa_pkg::ST_FAIL;
				end else begin
					unique case (cmd_q)
						bfa_pkg::CMD_ALLOC: begin
							res_addr_q <= pa;
							if (cur_bit) res_status_q <= bfa_pkg::ST_ALREADY;
						end
						bfa_pkg::CMD_FREE: begin
							if (!cur_bit) res_status_q <= bfa_pkg::ST_ALREADY;
						end
						bfa_pkg::CMD_IS_FREE: res_free_q <= !cur_bit;
						default:              res_addr_q <= pa;
					endcase
				end
			end else if (cmd_q == bfa_pkg::CMD_INDEX_OF) begin
				priority if (hit0) begin
					if (g0[36:IW] == '0) res_index_q <= g0[IW-1:0];
					else res_status_q <= bfa_pkg::ST_FAIL;
				end else if (hit1) begin
					if (g1[36:IW] == '0) res_index_q <= g1[IW-1:0];
					else res_status_q <= bfa_pkg::ST_FAIL;
				end else begin
					res_status_q <= bfa_pkg::ST_FAIL;
				end
			end else if (cmd_q != bfa_pkg::CMD_ALLOC_RUN && cmd_q != bfa_pkg::CMD_USED) begin
				res_status_q <= bfa_pkg::ST_FAIL;
			end
		end
		if (cmd.scan_fail) begin
			res_index_q  <= '0;
			res_addr_q   <= '0;
			res_free_q   <= 1'b0;
			res_status_q <= bfa_pkg::ST_FAIL;
		end
		if (cmd.fill_wr && sts.fill_last) begin
			res_index_q  <= start_q;
			res_addr_q   <= '0;
			res_free_q   <= 1'b0;
			res_status_q <= bfa_pkg::ST_OK;
		end
		// run search
		if (cmd.scan_init) begin
			i_q     <= '0;
			combo_q <= '0;
		end
		if (cmd.scan_bit) begin
			if (found) begin
				start_q <= st;
				end_q   <= end_full[IW-1:0];
				fw_q    <= st[IW-1:BW];
			end else begin
				combo_q <= free_b ? combo_p1 : '0;
				start_q <= st;
				i_q     <= i_q + CW'(1);
			end
		end
		if (cmd.fill_wr && !sts.fill_last) begin
			fw_q <= fw_q + 1'b1;
		end
		if (cmd.out_load) begin
			m_tdata_q <= {4'b0, res_status_q, used_q, res_free_q, res_addr_q, res_index_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (item_we) begin
				used_q <= (cmd_q == bfa_pkg::CMD_ALLOC) ? used_q + CW'(1) : used_q - CW'(1);
			end else if (cmd.fill_wr && sts.fill_last) begin
				used_q <= used_q + runlen_q;
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		sts.clr_done     = clr_cnt_q[WA];
		sts.cmd          = cmd_q;
		sts.run_zero     = runlen_q == '0;
		sts.scan_end     = i_q == cfg.total;
		sts.scan_found   = found;
		sts.scan_next_rd = (i_q[BW-1:0] == '1) || ((i_q + CW'(1)) == cfg.total);
		sts.fill_last    = fw_q == end_q[IW-1:BW];
		sts.out_busy     = m_tvalid_q && !m_tready;
	end

	a_used_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.exec || cmd.fill_wr) |=> $stable(used_q))
		else $error("used count changed outside an update");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(m_tvalid_q && !m_tready))
		else $error("result overwritten while waiting");
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_bit |-> (i_q < cfg.total))
		else $error("scan beyond frame limit");
	a_no_item_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |-> !(cmd.load || cmd.exec || cmd.fill_wr))
		else $error("bitmap access during clearing pass");

endmodule

[rtl/bitmap_frame_allocator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_top
// Bitmap page-frame allocator over two regions, first-fit run allocation.
// ----------------------------------------------------------------------------
// Commands enter on the s_ channel (command in s_tuser), one result per
// command leaves on the m_ channel. Region bases, sizes and the search limit
// are set via APB by the user, only with no command in flight (not enforced).
// Single-frame, translation and count commands pass a read and an execute
// state (one bitmap read-modify-write) before the result is loaded. A run
// allocation reads each 32-frame bitmap word searched and tests it one bit
// per cycle, then fills each word of the run with a read and a write, all
// through the single bitmap memory port.
// After reset the bitmap is swept to zero, one word a cycle, while s_tready
// stays low; APB writes are taken throughout.
// One command is in work at a time. The result sits in an output register, so
// the next command is taken while the receiver stalls; it then finishes and
// waits until that register drains.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// frame_index[15:0], address[63:16], run_length[80:64], zero pad
	input  logic [bfa_pkg::IN_W-1:0]     s_tdata,
	// command[2:0]
	input  logic [2:0]                   s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// result_index[15:0], result_address[63:16], is_free[64],
	// used_count[81:65], status[83:82], zero pad
	output logic [bfa_pkg::OUT_W-1:0]    m_tdata,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bfa_pkg::PADDR_W-1:0]  paddr,
	input  logic [bfa_pkg::PDATA_W-1:0]  pwdata,
	output logic [bfa_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);

	bfa_pkg::cfg_t     cfg;
	bfa_pkg::ctl_cmd_t cmd;
	bfa_pkg::ctl_sts_t sts;

	bfa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bfa_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bitmap frame allocator.
// ----------------------------------------------------------------------------
// Commands go in on the slave stream in random bursts. Results are taken
// under a stalling receiver. Each result is compared with a bit-level copy of
// the allocator's bitmap, used count and region set-up, kept in the bench.
// The region registers are rewritten between phases, once the allocator has
// gone quiet. Settings run from all zero to both regions at full size.
// ----------------------------------------------------------------------------
module tb;
	import bfa_pkg::*;

	localparam logic [2:0] CMD_BAD = 3'd7;
	localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [1:0]  status;
		logic [16:0] used;
		logic        free;
		logic [47:0] addr;
		logic [15:0] idx;
	} frame_result_t;

	class frame_scoreboard;
		bit            frame_used [MAX_FRAMES];
		logic [16:0]   in_use;
		logic [63:0]   base [2];
		logic [63:0]   frames [2];
		logic [63:0]   total;
		frame_result_t pending [$];
		int            mismatches;

		function new();
			in_use = '0;
			base = '{default: '0};
			frames = '{default: '0};
			total = '0;
			mismatches = 0;
		endfunction

		function void set_reg(input logic [2:0] rsel, input logic [63:0] v);
			case (rsel)
				REG_R0_BASE:   base[0] = v & MASK48;
				REG_R0_FRAMES: frames[0] = v & 64'h1FFFF;
				REG_R1_BASE:   base[1] = v & MASK48;
				REG_R1_FRAMES: frames[1] = v & 64'h1FFFF;
				REG_TOTAL:     total = v & 64'h1FFFF;
				default: ;
			endcase
		endfunction

		function bit find_region(input logic [63:0] gidx, output int rg,
				output logic [63:0] loc);
			logic [63:0] i;
			i = gidx;
			for (int r = 0; r < 2; r++) begin
				if (i < frames[r]) begin
					rg = r;
					loc = i;
					return 1;
				end
				i -= frames[r];
			end
			return 0;
		endfunction

		function bit in_bitmap(input logic [63:0] gidx);
			int rg;
			logic [63:0] loc;
			return gidx < MAX_FRAMES && find_region(gidx, rg, loc);
		endfunction

		// note an accepted command and work out its result
		function void note_command(input logic [2:0] cmd, input logic [15:0] fidx,
				input logic [47:0] addr, input logic [16:0] runlen);
			frame_result_t e;
			int rg;
			logic [63:0] loc, pa, b, lim, g, offset, start, combo;
			bit hit;
			e = '0;
			if (cmd <= CMD_ADDR_OF) begin
				e.idx = fidx;
				if (!in_bitmap(fidx)) begin
					e.status = ST_FAIL;
				end else begin
					void'(find_region(fidx, rg, loc));
					pa = (base[rg] + loc * 4096) & MASK48;
					case (cmd)
						CMD_ALLOC: begin
							if (frame_used[fidx]) e.status = ST_ALREADY;
							else begin
								frame_used[fidx] = 1;
								in_use++;
							end
							e.addr = pa[47:0];
						end
						CMD_FREE: begin
							if (!frame_used[fidx]) e.status = ST_ALREADY;
							else begin
								frame_used[fidx] = 0;
								in_use--;
							end
						end
						CMD_IS_FREE: e.free = !frame_used[fidx];
						default: e.addr = pa[47:0];
					endcase
				end
			end else if (cmd == CMD_INDEX_OF) begin
				e.status = ST_FAIL;
				offset = 0;
				for (int r = 0; r < 2; r++) begin
					b = base[r];
					lim = b + frames[r] * 4096;
					if (b <= addr && addr < lim) begin
						g = offset + (addr - b) / 4096;
						if (g <= 64'hFFFF) begin
							e.idx = g[15:0];
							e.status = ST_OK;
						end
						break;
					end
					offset += frames[r];
				end
			end else if (cmd == CMD_ALLOC_RUN) begin
				if (runlen != 0) begin
					start = 0;
					combo = 0;
					hit = 0;
					for (logic [63:0] i = 0; i < total; i++) begin
						if (!in_bitmap(i) || frame_used[i]) begin
							combo = 0;
							continue;
						end
						if (combo == 0) start = i;
						combo++;
						if (combo == runlen) begin
							hit = 1;
							break;
						end
					end
					if (hit) begin
						for (logic [63:0] i = 0; i < runlen; i++) frame_used[start + i] = 1;
						in_use += runlen;
						e.idx = start[15:0];
					end else begin
						e.status = ST_FAIL;
					end
				end
			end else if (cmd != CMD_USED) begin
				e.status = ST_FAIL;
			end
			e.used = in_use;
			pending.push_back(e);
		endfunction

		function void check_result(input logic [OUT_W-1:0] d);
			frame_result_t a, e;
			a.idx = d[15:0];
			a.addr = d[63:16];
			a.free = d[64];
			a.used = d[81:65];
			a.status = d[83:82];
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", d);
				return;
			end
			e = pending.pop_front();
			if (a.idx !== e.idx || a.addr !== e.addr || a.free !== e.free ||
					a.used !== e.used || a.status !== e.status || d[87:84] !== '0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: exp idx %h addr %h free %b used %h st %h",
						e.idx, e.addr, e.free, e.used, e.status);
					$display("          got idx %h addr %h free %b used %h st %h",
						a.idx, a.addr, a.free, a.used, a.status);
				end
			end
		endfunction
	endclass

	logic                clk = 0;
	logic                arst_n = 0;
	logic                s_tvalid = 0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata = '0;
	logic [2:0]          s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 0;
	logic [OUT_W-1:0]    m_tdata;
	logic                psel = 0;
	logic                penable = 0;
	logic                pwrite = 0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	frame_scoreboard sb = new();
	int burst_left = 0;
	int stall_mode = 0;
	int stall_age = 0;

	bitmap_frame_allocator_top dut (.*);

	initial forever #5 clk = ~clk;

	initial begin
		#100ms;
		$display("Some tests failed");
		$finish;
	end

	// receiver: stall pattern switches between open, patchy and mostly closed
	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_result(m_tdata);
		if (stall_age == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_age <= $urandom_range(20, 120);
		end else begin
			stall_age <= stall_age - 1;
		end
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= $urandom_range(0, 1);
			default: m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	task automatic reg_write(input logic [2:0] rsel, input logic [63:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(rsel * 8);
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.set_reg(rsel, v);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_regions(input logic [47:0] b0, input logic [16:0] f0,
			input logic [47:0] b1, input logic [16:0] f1, input logic [16:0] tot);
		drain();
		reg_write(REG_R0_BASE, b0);
		reg_write(REG_R0_FRAMES, f0);
		reg_write(REG_R1_BASE, b1);
		reg_write(REG_R1_FRAMES, f1);
		reg_write(REG_TOTAL, tot);
	endtask

	task automatic send(input logic [2:0] cmd, input logic [15:0] fidx,
			input logic [47:0] addr, input logic [16:0] runlen);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 8);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {7'd0, runlen, addr, fidx};
		do @(posedge clk); while (!s_tready);
		sb.note_command(cmd, fidx, addr, runlen);
		burst_left--;
	endtask

	task automatic rand_cmd(input int max_run);
		int w, span, r, k;
		logic [15:0] fidx;
		logic [47:0] addr;
		logic [16:0] runlen;
		span = sb.frames[0] + sb.frames[1] + 4;
		w = $urandom_range(0, 99);
		fidx = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, span - 1));
		addr = {16'($urandom), 32'($urandom)};
		runlen = 17'($urandom);
		if (w < 25) send(CMD_ALLOC, fidx, addr, runlen);
		else if (w < 45) send(CMD_FREE, fidx, addr, runlen);
		else if (w < 55) send(CMD_IS_FREE, fidx, addr, runlen);
		else if (w < 63) send(CMD_ADDR_OF, fidx, addr, runlen);
		else if (w < 75) begin
			// aim mostly inside a region, with the page offset random
			r = $urandom_range(0, 1);
			k = $urandom_range(0, sb.frames[r] + 1) - 1;
			if ($urandom_range(0, 4) != 0)
				addr = 48'(sb.base[r] + k * 4096 + $urandom_range(0, 4095));
			send(CMD_INDEX_OF, fidx, addr, runlen);
		end else if (w < 88) begin
			send(CMD_ALLOC_RUN, fidx, addr, 17'($urandom_range(0, max_run)));
		end else if (w < 95) begin
			send(CMD_USED, fidx, addr, runlen);
		end else begin
			w = $urandom_range(0, 7);
			send(w == CMD_ALLOC_RUN ? CMD_BAD : 3'(w), 16'($urandom), addr, runlen);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// all regions empty: every frame request fails
		send(CMD_ALLOC, 16'd0, '0, '0);
		send(CMD_INDEX_OF, '0, '0, '0);
		send(CMD_ALLOC_RUN, '0, '0, 17'd1);

		set_regions(48'h0000_1000_0000, 17'd40, 48'h0080_0000_0000, 17'd30, 17'd80);
		send(CMD_ALLOC, 16'd0, '0, '0);
		send(CMD_ALLOC, 16'd0, '0, '0);
		send(CMD_ALLOC, 16'd69, '0, '0);
		send(CMD_ALLOC, 16'd70, '0, '0);
		send(CMD_ALLOC, 16'hFFFF, MASK48, 17'h1FFFF);
		send(CMD_FREE, 16'd0, '0, '0);
		send(CMD_FREE, 16'd0, '0, '0);
		send(CMD_IS_FREE, 16'd69, '0, '0);
		send(CMD_IS_FREE, 16'd5, '0, '0);
		send(CMD_ADDR_OF, 16'd40, '0, '0);
		send(CMD_INDEX_OF, '0, 48'h0080_0000_2FFF, '0);
		send(CMD_INDEX_OF, '0, 48'h0000_1002_8000, '0);
		send(CMD_INDEX_OF, '0, MASK48, '0);
		send(CMD_ALLOC_RUN, '0, '0, 17'd0);
		send(CMD_ALLOC_RUN, '0, '0, 17'd38);
		send(CMD_ALLOC_RUN, '0, '0, 17'd10);
		send(CMD_ALLOC_RUN, '0, '0, 17'h10000);
		send(CMD_USED, '0, '0, '0);
		send(CMD_BAD, 16'd3, '0, '0);
		repeat (450) rand_cmd(6);

		// hold off until the allocator has emptied its output
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) rand_cmd(6);

		set_regions(48'h0000_0000_5000, 17'd0, 48'h1234_5678_9000, 17'd100, 17'd128);
		repeat (450) rand_cmd(8);

		// both regions full size; the first one wraps round the address space
		set_regions(48'hFFFF_FFFF_F000, 17'h10000, '0, 17'h10000, 17'h10000);
		send(CMD_ADDR_OF, 16'd1, '0, '0);
		send(CMD_INDEX_OF, '0, 48'h0000_0100_0000, '0);
		send(CMD_INDEX_OF, '0, 48'hFFFF_FFFF_F800, '0);
		send(CMD_ALLOC_RUN, '0, '0, 17'h10000);
		repeat (150) rand_cmd(4);

		set_regions(48'($urandom) << 12, 17'($urandom_range(1, 90)), 48'h7000_0000_0000,
			17'($urandom_range(1, 90)), 17'($urandom_range(1, 200)));
		repeat (250) rand_cmd(10);

		drain();
		if (sb.mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
